### rtl/core/wbss_pkg.sv
// Shared types and constants for the wildcard byte signature scanner.
// Used by every module under rtl/core; depends on nothing else.
package wbss_pkg;

    localparam int REG_POSITIONS     = 16;
    localparam int MAX_SIGNATURE_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int ADDR_W            = 64;

    typedef enum logic [1:0] {
        CFG_SIG_LOW  = 2'd0,
        CFG_SIG_HIGH = 2'd1,
        CFG_WILDCARD = 2'd2,
        CFG_LENGTH   = 2'd3
    } cfg_index_t;

    // One pending result: the address is that of the newest matched byte,
    // the back end subtracts len_m1 to get the start of the match.
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        len_m1;
    } result_t;

endpackage

### rtl/core/wildcard_byte_signature_scan_core.sv
// Top level of the wildcard byte signature scanner.
// Depends on wbss_pkg, wbss_front, wbss_queue and wbss_back.
//
// Region bytes enter on a queue-like port: a word is taken at a clock edge
// with push high and full low. Mark the first byte of a region with
// first_of_region (region_base is sampled then) and the final byte with
// last_of_region. At most one result word per region comes out: a match
// with the address of its first byte, or not-found when the last byte
// passes unmatched. Results leave on a second queue-like port: the word
// shown while empty is low is taken with pop.
// The signature registers are written through the cfg channel, which is
// always ready; write them only while no region is in flight.
// A byte is taken every cycle while full is low. The compare of all signature positions runs
// in parallel in the front end; a result passes through the front stage register,
// the queue and the output register. When the receiver stalls, results wait in
// a four-word queue and a front stage register; full rises only once both
// are occupied. Reset clears the window, count, address, match latch, the
// queue and the output, and loads the register reset values.
module wildcard_byte_signature_scan_core #(
    parameter int MAX_SIGNATURE = wbss_pkg::MAX_SIGNATURE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  wbss_pkg::cfg_index_t        cfg_index,
    input  logic [63:0]                 cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  data_byte,
    input  logic                        first_of_region,
    input  logic                        last_of_region,
    input  logic [wbss_pkg::ADDR_W-1:0] region_base,
    output logic                        empty,
    input  logic                        pop,
    output logic                        match_found,
    output logic [wbss_pkg::ADDR_W-1:0] match_address
);
    import wbss_pkg::*;

    logic    stage_valid;
    result_t stage_word;
    logic    q_full;
    logic    q_valid;
    logic    q_rd;
    result_t q_word;

    wbss_front #(
        .MAX_SIGNATURE(MAX_SIGNATURE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .first_of_region(first_of_region),
        .last_of_region (last_of_region),
        .region_base    (region_base),
        .q_full         (q_full),
        .stage_valid    (stage_valid),
        .stage_word     (stage_word)
    );

    wbss_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (stage_valid),
        .wr_word(stage_word),
        .rd_en  (q_rd),
        .q_full (q_full),
        .q_valid(q_valid),
        .rd_word(q_word)
    );

    wbss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .match_found  (match_found),
        .match_address(match_address)
    );

    // The input only backs up when the front stage is holding a word.
    assert property (@(posedge clk) disable iff (!rst_n) full |-> stage_valid)
        else $error("full raised with an empty front stage");

    // A stage word blocked by a full queue must still be there next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && q_full) |=> stage_valid)
        else $error("front stage word lost while the queue was full");

    // A new output word can only come from the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(empty) && !empty) |-> $past(q_valid))
        else $error("output word appeared without a queued word");

    // A not-found word always carries address zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !match_found) |-> (match_address == '0))
        else $error("not-found word with a nonzero address");

endmodule

### rtl/core/wbss_front.sv
// Front end: configuration registers, byte window, region tracking and the
// parallel signature compare. Depends on wbss_pkg.
module wbss_front #(
    parameter int MAX_SIGNATURE = wbss_pkg::MAX_SIGNATURE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  wbss_pkg::cfg_index_t       cfg_index,
    input  logic [63:0]                cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 data_byte,
    input  logic                       first_of_region,
    input  logic                       last_of_region,
    input  logic [wbss_pkg::ADDR_W-1:0] region_base,
    input  logic                       q_full,
    output logic                       stage_valid,
    output wbss_pkg::result_t          stage_word
);
    import wbss_pkg::*;

    localparam int WIN_DEPTH = MAX_SIGNATURE - 1;
    localparam int SEEN_W    = $clog2(MAX_SIGNATURE + 1);
    localparam int LIM       = (MAX_SIGNATURE < REG_POSITIONS) ? MAX_SIGNATURE
                                                               : REG_POSITIONS;
    localparam int CMP_W     = (SEEN_W > 5) ? SEEN_W : 5;

    logic [63:0]         sig_low_reg;
    logic [63:0]         sig_high_reg;
    logic [15:0]         wild_reg;
    logic [4:0]          sig_len_reg;

    logic [7:0]          window_reg [WIN_DEPTH];
    logic [SEEN_W-1:0]   seen_reg;
    logic [SEEN_W-1:0]   seen_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr_cur;
    logic                latch_reg;
    logic                latch_eff;

    logic                stage_valid_reg;
    result_t             stage_word_reg;

    logic                accept;
    logic [4:0]          len_act;
    logic [127:0]        sig_all;
    logic [7:0]          cand [REG_POSITIONS];
    logic [REG_POSITIONS-1:0] lane_ok;
    logic                hit;
    logic                emit;

    assign cfg_ready   = 1'b1;
    assign full        = stage_valid_reg && q_full;
    assign accept      = push && !full;
    assign stage_valid = stage_valid_reg;
    assign stage_word  = stage_word_reg;
    assign sig_all     = {sig_high_reg, sig_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_low_reg  <= '0;
            sig_high_reg <= '0;
            wild_reg     <= '0;
            sig_len_reg  <= 5'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIG_LOW:  sig_low_reg  <= cfg_data;
                CFG_SIG_HIGH: sig_high_reg <= cfg_data;
                CFG_WILDCARD: wild_reg     <= cfg_data[15:0];
                CFG_LENGTH:   sig_len_reg  <= cfg_data[4:0];
            endcase
        end
    end

    always_comb
    begin
        priority if (sig_len_reg == 5'd0)
            len_act = 5'd1;
        else if (sig_len_reg > 5'(LIM))
            len_act = 5'(LIM);
        else
            len_act = sig_len_reg;
    end

    // A first byte sees a cleared region: empty window, zero count, no latch.
    assign latch_eff = first_of_region ? 1'b0 : latch_reg;
    assign addr_cur  = first_of_region ? region_base : addr_reg;

    always_comb
    begin
        logic [SEEN_W-1:0] seen_eff;
        seen_eff  = first_of_region ? '0 : seen_reg;
        seen_next = (seen_eff < SEEN_W'(MAX_SIGNATURE)) ? seen_eff + 1'b1 : seen_eff;
    end

    // Tap a holds the byte that arrived a items before the current one.
    genvar ga;
    generate
        for (ga = 0; ga < REG_POSITIONS; ga++)
        begin : g_cand
            if (ga == 0)
            begin : g_new
                assign cand[ga] = data_byte;
            end
            else if (ga - 1 < WIN_DEPTH)
            begin : g_tap
                assign cand[ga] = first_of_region ? 8'h00 : window_reg[ga-1];
            end
            else
            begin : g_none
                assign cand[ga] = 8'h00;
            end
        end
    endgenerate

    // Tap a lines up with signature position len-1-a.
    always_comb
    begin
        logic [3:0] pos;
        for (int a = 0; a < REG_POSITIONS; a++)
        begin
            pos = 4'(len_act - 5'd1 - 5'(a));
            lane_ok[a] = (5'(a) >= len_act) || wild_reg[pos]
                         || (cand[a] == sig_all[pos*8 +: 8]);
        end
    end

    assign hit  = !latch_eff && (CMP_W'(seen_next) >= CMP_W'(len_act)) && (&lane_ok);
    assign emit = hit || (last_of_region && !latch_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
                window_reg[i] <= 8'h00;
            seen_reg  <= '0;
            addr_reg  <= '0;
            latch_reg <= 1'b0;
        end
        else if (accept)
        begin
            window_reg[0] <= data_byte;
            for (int i = 1; i < WIN_DEPTH; i++)
                window_reg[i] <= first_of_region ? 8'h00 : window_reg[i-1];
            seen_reg  <= seen_next;
            addr_reg  <= addr_cur + 1'b1;
            latch_reg <= latch_eff || hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (accept && emit)
            stage_valid_reg <= 1'b1;
        else if (!q_full)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            stage_word_reg.found  <= hit;
            stage_word_reg.addr   <= addr_cur;
            stage_word_reg.len_m1 <= 4'(len_act - 5'd1);
        end
    end

endmodule

### rtl/core/wbss_queue.sv
// Short result queue between the front end and the back end.
// Register based, one write and one read per cycle. Depends on wbss_pkg.
module wbss_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  wbss_pkg::result_t wr_word,
    input  logic              rd_en,
    output logic              q_full,
    output logic              q_valid,
    output wbss_pkg::result_t rd_word
);
    import wbss_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_word = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_rd)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_word;
    end

endmodule

### rtl/core/wbss_back.sv
// Back end: forms the final match address and holds the result word
// in the output register until it is popped. Depends on wbss_pkg.
module wbss_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  wbss_pkg::result_t           q_word,
    output logic                        q_rd,
    input  logic                        pop,
    output logic                        empty,
    output logic                        match_found,
    output logic [wbss_pkg::ADDR_W-1:0] match_address
);
    import wbss_pkg::*;

    logic              out_valid_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              load;

    assign load          = q_valid && (!out_valid_reg || pop);
    assign q_rd          = load;
    assign empty         = !out_valid_reg;
    assign match_found   = found_reg;
    assign match_address = addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg <= q_word.found;
            addr_reg  <= q_word.found ? q_word.addr - ADDR_W'(q_word.len_m1)
                                      : '0;
        end
    end

endmodule
